// File: sv/aprq_pkg.sv
package aprq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 2;
    localparam int ID_W     = 16;
    localparam int RANK_W   = 4;
    localparam int WAIT_W   = 16;
    localparam int ARR_W    = 16;
    localparam int ST_W     = 2;
    localparam int OCC_W    = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_TICK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [RANK_W-1:0] rank;
        logic [WAIT_W-1:0] wait_cnt;
        logic [ARR_W-1:0]  arrival;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic load;       // take the input item, store it if it is an insert and the queue is not full
        logic sweep;      // walk slots 0 .. count-1 through the read port
        logic tick_mode;  // sweep ages entries instead of searching
        logic move;       // fill the vacated slot with the last entry
        logic publish;    // load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic sweep_done;
        logic out_free;
    } t_stat;

endpackage

// File: sv/aging_priority_queue.sv
// channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------------
// input    | i_valid / o_ready   | i_operation, i_item_id, i_rank
// output   | o_valid / i_ready   | o_status, o_out_id, o_out_rank,
//          |                     | o_waited_ticks, o_occupancy, o_is_empty
//
// Insert, no-op and empty remove are accepted, then the output register is loaded.
// Remove and tick walk the N stored entries of the entry memory one slot per cycle
// through its single registered read port.
// Reset (synchronous, active low) empties the queue; no clearing pass is run.
// A result waits in the controller while the output register is still held;
// o_ready is high only between items.
module aging_priority_queue
    import aprq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [ID_W-1:0]     i_item_id,
    input  logic [RANK_W-1:0]   i_rank,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [ST_W-1:0]     o_status,
    output logic [ID_W-1:0]     o_out_id,
    output logic [RANK_W-1:0]   o_out_rank,
    output logic [WAIT_W-1:0]   o_waited_ticks,
    output logic [OCC_W-1:0]    o_occupancy,
    output logic                o_is_empty
);

    t_cmd  cmd;
    t_stat stat;

    aprq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_ready     (o_ready),
        .o_cmd       (cmd)
    );

    aprq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_operation    (i_operation),
        .i_item_id      (i_item_id),
        .i_rank         (i_rank),
        .i_ready        (i_ready),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_rank     (o_out_rank),
        .o_waited_ticks (o_waited_ticks),
        .o_occupancy    (o_occupancy),
        .o_is_empty     (o_is_empty)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken again right after an item");

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> (!o_valid || i_ready))
        else $error("result overwrote an item not yet taken");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_occupancy == OCC_W'(CAPACITY)))
        else $error("full status with room left");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |->
            (o_is_empty && (o_out_id == '0) && (o_waited_ticks == '0)))
        else $error("empty remove carries entry data");

endmodule

// File: sv/aprq_ctrl.sv
module aprq_ctrl
    import aprq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [OP_W-1:0]     i_operation,
    input  t_stat               i_stat,
    output logic                o_ready,
    output t_cmd                o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (t_op'(i_operation))
                        OP_REMOVE: n_state = i_stat.empty ? S_DONE : S_SCAN;
                        OP_TICK:   n_state = S_TICK;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = S_DONE;
            end
            S_TICK: begin
                o_cmd.sweep     = 1'b1;
                o_cmd.tick_mode = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register can take it
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: sv/aprq_dp.sv
module aprq_dp
    import aprq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [ID_W-1:0]     i_item_id,
    input  logic [RANK_W-1:0]   i_rank,
    input  logic                i_ready,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic                o_valid,
    output logic [ST_W-1:0]     o_status,
    output logic [ID_W-1:0]     o_out_id,
    output logic [RANK_W-1:0]   o_out_rank,
    output logic [WAIT_W-1:0]   o_waited_ticks,
    output logic [OCC_W-1:0]    o_occupancy,
    output logic                o_is_empty
);

    t_entry             r_mem [CAPACITY];
    t_entry             r_rd_data;

    logic [CNT_W-1:0]   r_count;
    logic [ARR_W-1:0]   r_arrival;
    t_op                r_op;
    logic               r_flag;

    logic [CNT_W-1:0]   r_idx;
    logic               r_dv;
    logic [IDX_W-1:0]   r_pidx;

    logic [IDX_W-1:0]   r_best_slot;
    logic [RANK_W-1:0]  r_best_rank;
    logic [ARR_W-1:0]   r_best_age;
    logic [ID_W-1:0]    r_best_id;
    logic [WAIT_W-1:0]  r_best_wait;
    t_entry             r_last;

    logic               r_o_valid;
    t_status            r_o_status;
    logic [ID_W-1:0]    r_o_id;
    logic [RANK_W-1:0]  r_o_rank;
    logic [WAIT_W-1:0]  r_o_wait;
    logic [OCC_W-1:0]   r_o_occ;
    logic               r_o_empty;

    logic               full;
    logic               is_insert;
    logic               do_insert;
    logic               issue;
    logic               scan_eval;
    logic               tick_wb;
    logic [ARR_W-1:0]   age;
    logic               take;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    t_entry             mem_wd;
    t_entry             aged;

    assign full      = (r_count == CNT_W'(CAPACITY));
    assign is_insert = (t_op'(i_operation) == OP_INSERT);
    assign do_insert = i_cmd.load && is_insert && !full;
    assign issue     = i_cmd.sweep && (r_idx < r_count);
    assign scan_eval = i_cmd.sweep && !i_cmd.tick_mode && r_dv;
    assign tick_wb   = i_cmd.sweep && i_cmd.tick_mode && r_dv;

    assign age  = r_arrival - r_rd_data.arrival;
    // older entry wins a rank tie; the lower slot wins a full tie
    assign take = (r_pidx == '0) || (r_rd_data.rank < r_best_rank) ||
                  ((r_rd_data.rank == r_best_rank) && (age > r_best_age));

    always_comb begin
        aged = r_rd_data;
        if (r_rd_data.wait_cnt != '1) begin
            aged.wait_cnt = r_rd_data.wait_cnt + WAIT_W'(1);
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_pidx;
        mem_wd = aged;
        if (do_insert) begin
            mem_we = 1'b1;
            mem_wa = r_count[IDX_W-1:0];
            mem_wd = '{id: i_item_id, rank: i_rank, wait_cnt: '0, arrival: r_arrival};
        end else if (i_cmd.move) begin
            mem_we = 1'b1;
            mem_wa = r_best_slot;
            mem_wd = r_last;
        end else if (tick_wb) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_arrival <= '0;
            r_idx     <= '0;
            r_dv      <= 1'b0;
            r_op      <= OP_NONE;
            r_flag    <= 1'b0;
        end else begin
            r_dv <= issue;
            if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_op   <= t_op'(i_operation);
                r_flag <= (is_insert && full) ||
                          ((t_op'(i_operation) == OP_REMOVE) && (r_count == '0));
                r_idx  <= '0;
            end
            if (do_insert) begin
                r_count   <= r_count + CNT_W'(1);
                r_arrival <= r_arrival + ARR_W'(1);
            end
            if (i_cmd.move) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx[IDX_W-1:0];
        if (scan_eval) begin
            if (take) begin
                r_best_slot <= r_pidx;
                r_best_rank <= r_rd_data.rank;
                r_best_age  <= age;
                r_best_id   <= r_rd_data.id;
                r_best_wait <= r_rd_data.wait_cnt;
            end
            if (CNT_W'(r_pidx) == r_count - CNT_W'(1)) begin
                r_last <= r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_o_status <= ST_OK;
            r_o_id     <= '0;
            r_o_rank   <= '0;
            r_o_wait   <= '0;
            r_o_occ    <= OCC_W'(r_count);
            r_o_empty  <= (r_count == '0);
            case (r_op)
                OP_INSERT: begin
                    if (r_flag) begin
                        r_o_status <= ST_FULL;
                    end
                end
                OP_REMOVE: begin
                    if (r_flag) begin
                        r_o_status <= ST_EMPTY;
                    end else begin
                        r_o_id   <= r_best_id;
                        r_o_rank <= r_best_rank;
                        r_o_wait <= r_best_wait;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.empty      = (r_count == '0);
    assign o_stat.sweep_done = (r_idx == r_count) && !r_dv;
    assign o_stat.out_free   = !r_o_valid || i_ready;

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_out_id       = r_o_id;
    assign o_out_rank     = r_o_rank;
    assign o_waited_ticks = r_o_wait;
    assign o_occupancy    = r_o_occ;
    assign o_is_empty     = r_o_empty;

endmodule
